@@ hw/rtl/tbsm_pkg.sv @@
// Package for the time bucket slot manager.
// Holds widths, register indexes, reset values and the channel words.
// No dependencies.
package tbsm_pkg;

  localparam int TS_W       = 32;  // timestamp and start time width
  localparam int PER_W      = 31;  // period register width
  localparam int SLOTS_W    = 6;   // slot count register width
  localparam int SLOT_IDX_W = 5;   // slot index field width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIV_STEPS  = 32;  // one quotient bit per step
  localparam int DIV_CNT_W  = 5;

  localparam logic [PER_W-1:0]   PERIOD_RESET = PER_W'(60);
  localparam logic [SLOTS_W-1:0] SLOTS_RESET  = SLOTS_W'(1);
  localparam logic [TS_W-1:0]    START_MAX    = {TS_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 2'd0,
    REG_SLOTS  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_word_t;

  typedef struct packed {
    logic [TS_W-1:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [TS_W-1:0]       bucket_start;
    logic                  hit;
    logic                  from_history;
    logic                  evicted;
    logic [TS_W-1:0]       evicted_start;
  } out_word_t;

endpackage

@@ hw/rtl/tbsm_stream_if.sv @@
// Valid/ready channel used for the config, input and result words.
// The word type is set by the instantiating level (see tbsm_pkg).
interface tbsm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/time_bucket_slot_manager.sv @@
// Time bucket slot manager: rounds timestamps to bucket starts and maps them to slots.
// Depends on tbsm_pkg, tbsm_stream_if and tbsm_ram.
//
// Channel   Dir   Word         Handshake
// cfg_i     in    cfg_word_t   valid/ready, ready always high
// in_i      in    in_word_t    valid/ready, ready only while idle
// out_o     out   out_word_t   valid/ready, held in an output register
//
// Flow: an item goes through a 32-step remainder loop on one shared subtractor,
// then a slot scan at one slot per cycle (slot RAM read port). A miss then walks
// the history RAM for a reuse and scans the slots for the oldest one to fill next.
// Reset: after rst_ni rises the history RAM is zeroed one entry per cycle,
// in_i.ready stays low meanwhile, config writes are taken.
// Stalls: a finished word waits in the output register; the next item is taken
// meanwhile, and its result waits for that register to empty.
module time_bucket_slot_manager
  import tbsm_pkg::*;
#(
  parameter int MAX_SLOTS     = 32,
  parameter int HISTORY_DEPTH = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tbsm_stream_if.sink   cfg_i,
  tbsm_stream_if.sink   in_i,
  tbsm_stream_if.source out_o
);

  localparam int SW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;  // slot index
  localparam int NW  = $clog2(MAX_SLOTS + 1);                    // slot count
  localparam int HW  = $clog2(HISTORY_DEPTH);                    // history index
  localparam int HCW = $clog2(HISTORY_DEPTH + 1);                // history count

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_ROUND,
    S_SCAN,
    S_EVRD,
    S_EVCHK,
    S_HIST,
    S_FILL,
    S_OLD,
    S_DONE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [PER_W-1:0]   per_q;
  logic [SLOTS_W-1:0] slots_q;

  // Slot and history bookkeeping
  logic [MAX_SLOTS-1:0] slot_valid_q;
  logic [SW-1:0]        oldest_q;
  logic [HW-1:0]        ptr_q;

  // Per-item working registers
  logic [TS_W-1:0]      t_q;
  logic [TS_W-1:0]      dvd_q;
  logic [TS_W-1:0]      rem_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [NW-1:0]        scnt_q;
  logic [HCW-1:0]       hcnt_q;
  logic [HW-1:0]        haddr_q;
  logic                 chk_vld_q;
  logic                 chk_last_q;
  logic [SW-1:0]        chk_idx_q;
  logic [TS_W-1:0]      best_q;
  logic [SW-1:0]        slot_q;
  logic                 hit_q;
  logic                 hist_q;
  logic                 ev_q;
  logic [TS_W-1:0]      evs_q;

  // Output register
  logic      out_vld_q;
  out_word_t out_q;

  // Derived control
  logic [TS_W-1:0] per_eff;
  logic [NW-1:0]   n_eff;
  logic            s_issue;
  logic            h_issue;
  logic [HW-1:0]   ptr_next;
  logic [HW-1:0]   haddr_prev;

  // Shared arithmetic
  logic [TS_W-1:0] sh_d;
  logic [TS_W-1:0] sub_a;
  logic [TS_W-1:0] sub_b;
  logic [TS_W-1:0] sub_res;
  logic            div_ge;
  logic [TS_W-1:0] cmp_start;
  logic [TS_W-1:0] win_end;
  logic            win;
  logic            lt_best;

  // Memories
  logic [TS_W-1:0] slot_rdata;
  logic [SW-1:0]   slot_raddr;
  logic            slot_we;
  logic [TS_W-1:0] hist_rdata;
  logic            hist_we;
  logic [HW-1:0]   hist_waddr;
  logic [TS_W-1:0] hist_wdata;

  // A zero period acts as one; the slot count is clamped to 1..MAX_SLOTS.
  assign per_eff = (per_q == '0) ? TS_W'(1) : {1'b0, per_q};

  always_comb begin
    if (slots_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(slots_q) > MAX_SLOTS) begin
      n_eff = NW'(MAX_SLOTS);
    end else begin
      n_eff = NW'(slots_q);
    end
  end

  assign s_issue    = (scnt_q < n_eff);
  assign h_issue    = (hcnt_q < HCW'(HISTORY_DEPTH));
  assign ptr_next   = (ptr_q == HW'(HISTORY_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  assign haddr_prev = (haddr_q == '0) ? HW'(HISTORY_DEPTH - 1) : haddr_q - 1'b1;

  // One subtractor: remainder steps while dividing, then the round-down.
  assign sh_d    = {rem_q[TS_W-2:0], dvd_q[TS_W-1]};
  assign sub_a   = (state_q == S_DIV) ? sh_d : t_q;
  assign sub_b   = (state_q == S_DIV) ? per_eff : rem_q;
  assign sub_res = sub_a - sub_b;
  assign div_ge  = (sh_d >= per_eff);

  // Window test on whichever store is being walked; the end wraps at 32 bits.
  assign cmp_start = (state_q == S_HIST) ? hist_rdata : slot_rdata;
  assign win_end   = cmp_start + per_eff;
  assign win       = (t_q >= cmp_start) && (t_q < win_end);
  assign lt_best   = (slot_rdata < best_q);

  // Slot start store: slot_valid_q guards every read, so it needs no clearing.
  assign slot_raddr = (state_q == S_EVRD) ? oldest_q : scnt_q[SW-1:0];
  assign slot_we    = (state_q == S_FILL);

  tbsm_ram #(
    .WIDTH (TS_W),
    .DEPTH (MAX_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_q),
    .wdata_i (t_q),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  // History ring: zeroed by the clearing pass, then written on a history miss.
  assign hist_we    = (state_q == S_CLEAR) ||
                      ((state_q == S_HIST) && chk_vld_q && !win && chk_last_q);
  assign hist_waddr = (state_q == S_CLEAR) ? haddr_q : ptr_next;
  assign hist_wdata = (state_q == S_CLEAR) ? '0 : t_q;

  tbsm_ram #(
    .WIDTH (TS_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .raddr_i (haddr_q),
    .rdata_o (hist_rdata)
  );

  // Configuration writes; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per_q   <= PERIOD_RESET;
      slots_q <= SLOTS_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.data.index))
        REG_PERIOD: per_q   <= cfg_i.data.wdata[PER_W-1:0];
        REG_SLOTS:  slots_q <= cfg_i.data.wdata[SLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Sequencer: state, working registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      slot_valid_q <= '0;
      oldest_q     <= '0;
      ptr_q        <= '0;
      t_q          <= '0;
      dvd_q        <= '0;
      rem_q        <= '0;
      div_cnt_q    <= '0;
      scnt_q       <= '0;
      hcnt_q       <= '0;
      haddr_q      <= '0;
      chk_vld_q    <= 1'b0;
      chk_last_q   <= 1'b0;
      chk_idx_q    <= '0;
      best_q       <= START_MAX;
      slot_q       <= '0;
      hit_q        <= 1'b0;
      hist_q       <= 1'b0;
      ev_q         <= 1'b0;
      evs_q        <= '0;
      out_vld_q    <= 1'b0;
      out_q        <= '0;
    end else begin
      // Drop the word once taken; S_DONE handles the register itself.
      if (out_vld_q && out_o.ready && (state_q != S_DONE)) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        S_CLEAR: begin
          // Zero the history ring one entry per cycle.
          if (haddr_q == HW'(HISTORY_DEPTH - 1)) begin
            haddr_q <= '0;
            state_q <= S_IDLE;
          end else begin
            haddr_q <= haddr_q + 1'b1;
          end
        end

        S_IDLE: begin
          if (in_i.valid) begin
            t_q       <= in_i.data.timestamp;
            dvd_q     <= in_i.data.timestamp;
            rem_q     <= '0;
            div_cnt_q <= '0;
            state_q   <= S_DIV;
          end
        end

        S_DIV: begin
          // Restoring remainder, one dividend bit per cycle.
          rem_q     <= div_ge ? sub_res : sh_d;
          dvd_q     <= {dvd_q[TS_W-2:0], 1'b0};
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= S_ROUND;
          end
        end

        S_ROUND: begin
          t_q       <= sub_res;
          hit_q     <= 1'b0;
          hist_q    <= 1'b0;
          ev_q      <= 1'b0;
          evs_q     <= '0;
          scnt_q    <= '0;
          chk_vld_q <= 1'b0;
          state_q   <= S_SCAN;
        end

        S_SCAN: begin
          // Read one slot per cycle, test the one read last cycle.
          chk_vld_q  <= s_issue;
          chk_idx_q  <= scnt_q[SW-1:0];
          chk_last_q <= (scnt_q == n_eff - 1'b1);
          if (s_issue) begin
            scnt_q <= scnt_q + 1'b1;
          end
          if (chk_vld_q && slot_valid_q[chk_idx_q] && win) begin
            hit_q   <= 1'b1;
            slot_q  <= chk_idx_q;
            t_q     <= slot_rdata;
            state_q <= S_DONE;
          end else if (chk_vld_q && chk_last_q) begin
            slot_q  <= oldest_q;
            state_q <= S_EVRD;
          end
        end

        S_EVRD: begin
          state_q <= S_EVCHK;
        end

        S_EVCHK: begin
          ev_q      <= slot_valid_q[slot_q];
          evs_q     <= slot_valid_q[slot_q] ? slot_rdata : '0;
          haddr_q   <= ptr_q;
          hcnt_q    <= '0;
          chk_vld_q <= 1'b0;
          state_q   <= S_HIST;
        end

        S_HIST: begin
          // Walk the ring backward from the pointer, one entry per cycle.
          chk_vld_q  <= h_issue;
          chk_last_q <= (hcnt_q == HCW'(HISTORY_DEPTH - 1));
          if (h_issue) begin
            hcnt_q  <= hcnt_q + 1'b1;
            haddr_q <= haddr_prev;
          end
          if (chk_vld_q && win) begin
            t_q     <= hist_rdata;
            hist_q  <= 1'b1;
            state_q <= S_FILL;
          end else if (chk_vld_q && chk_last_q) begin
            ptr_q   <= ptr_next;
            state_q <= S_FILL;
          end
        end

        S_FILL: begin
          slot_valid_q[slot_q] <= 1'b1;
          scnt_q               <= '0;
          chk_vld_q            <= 1'b0;
          best_q               <= START_MAX;
          state_q              <= S_OLD;
        end

        S_OLD: begin
          // Oldest pick: first invalid slot, else first lowest start.
          chk_vld_q  <= s_issue;
          chk_idx_q  <= scnt_q[SW-1:0];
          chk_last_q <= (scnt_q == n_eff - 1'b1);
          if (s_issue) begin
            scnt_q <= scnt_q + 1'b1;
          end
          if (chk_vld_q) begin
            if (!slot_valid_q[chk_idx_q]) begin
              oldest_q <= chk_idx_q;
              state_q  <= S_DONE;
            end else begin
              if (lt_best) begin
                best_q   <= slot_rdata;
                oldest_q <= chk_idx_q;
              end
              if (chk_last_q) begin
                state_q <= S_DONE;
              end
            end
          end
        end

        S_DONE: begin
          // Hold until the output register is free.
          if (!out_vld_q || out_o.ready) begin
            out_vld_q           <= 1'b1;
            out_q.slot_index    <= SLOT_IDX_W'(slot_q);
            out_q.bucket_start  <= t_q;
            out_q.hit           <= hit_q;
            out_q.from_history  <= hist_q;
            out_q.evicted       <= ev_q;
            out_q.evicted_start <= evs_q;
            state_q             <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A hit never reports history reuse or an eviction.
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.hit) |-> (!out_q.from_history && !out_q.evicted))
    else $error("hit word carries miss flags");

  // The closed start is zero unless a slot was evicted.
  a_evs_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.evicted) |-> (out_q.evicted_start == '0))
    else $error("evicted_start set without eviction");

  // The history pointer moves only by one step, and only at the end of a walk.
  a_ptr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ptr_q != $past(ptr_q)) |->
      (($past(state_q) == S_HIST) &&
       (ptr_q == (($past(ptr_q) == HW'(HISTORY_DEPTH - 1)) ? HW'(0)
                                                           : HW'($past(ptr_q) + 1'b1)))))
    else $error("history pointer jumped");

  // The filled slot is valid from then on.
  a_fill_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |=> slot_valid_q[$past(slot_q)])
    else $error("filled slot not marked valid");

endmodule

@@ hw/rtl/tbsm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
